// ===== rtl/macc_pkg.sv =====
// Shared constants and types for the moving-average crossover counter.
package macc_pkg;

    localparam int WINDOW_MAX = 256;
    localparam int PRICE_W    = 16;
    localparam int WIN_W      = $clog2(WINDOW_MAX) + 1;
    localparam int PTR_W      = $clog2(WINDOW_MAX);
    localparam int SUM_W      = PRICE_W + PTR_W;
    localparam int PROD_W     = SUM_W + WIN_W;
    localparam int COUNT_W    = 16;

    // register word index on the config port
    localparam logic REG_SHORT_WIN = 1'b0;
    localparam logic REG_LONG_WIN  = 1'b1;

    localparam logic [WIN_W-1:0] SHORT_WIN_RST = WIN_W'(5);
    localparam logic [WIN_W-1:0] LONG_WIN_RST  = WIN_W'(20);

    // side codes, two's complement
    localparam logic [1:0] SIDE_NONE = 2'b00;
    localparam logic [1:0] SIDE_UP   = 2'b01;
    localparam logic [1:0] SIDE_DOWN = 2'b11;

    // item after classification by the front end
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [PTR_W-1:0]   wp;      // history slot this sample goes to
        logic               last;
        logic               first;   // first sample of a series
        logic               drop_s;  // oldest sample leaves the short window
        logic               drop_l;  // oldest sample leaves the long window
        logic               ready;   // both windows full after this sample
    } t_item;

    typedef struct packed {
        logic [COUNT_W-1:0] crossing_count;
        logic               crossed;
        logic               averages_ready;
        logic [1:0]         side;
        logic               end_of_series;
    } t_result;

    // front-to-back queue head
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage

// ===== rtl/moving_average_crossover_counter.sv =====
// Top level: config registers, front end and back end of the crossover counter.
//
// Usage:
//  - Input queue: drive i_price and i_last with push high; the sample is taken
//    at a clock edge where full is low. i_last marks the final sample of a
//    series; the series state clears after it.
//  - Result queue: one result per sample, in order. While empty is low the
//    oldest result sits on the o_* result ports; pop takes it.
//  - Config: APB-style, short window at byte 0, long window at byte 4, 9 bits
//    each. A window of 0 acts as 1, above 256 as 256. Any register write also
//    starts a new series. Write only while the block is idle; pready is tied
//    high.
//  - Throughput: one sample per cycle while results are popped. The history
//    memory has two read ports and one write port, so both aged samples
//    come out together. A taken sample passes history read, sum update,
//    cross multiply and compare on its way to the result ports.
//  - Reset: windows return to 5 and 20, the series is empty. The history needs
//    no clearing pass: entries are only read once the fill count shows them
//    written in the current series.
//  - Stall: an 8-entry result queue absorbs results; once it is committed the
//    back end stops drawing from the 4-entry input queue and full rises.
module moving_average_crossover_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample input
    input  logic                          push,
    output logic                          full,
    input  logic [macc_pkg::PRICE_W-1:0]  i_price,
    input  logic                          i_last,
    // results
    output logic                          empty,
    input  logic                          pop,
    output logic [macc_pkg::COUNT_W-1:0]  o_crossing_count,
    output logic                          o_crossed,
    output logic                          o_averages_ready,
    output logic signed [1:0]             o_side,
    output logic                          o_end_of_series,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int WW = macc_pkg::WIN_W;

    logic [WW-1:0]            r_short_win;
    logic [WW-1:0]            r_long_win;
    logic [WW-1:0]            s_len;
    logic [WW-1:0]            l_len;
    logic                     cfg_wr;
    logic                     reg_sel;
    logic                     q_pop;
    macc_pkg::t_queue_head    head;
    macc_pkg::t_result        result;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_win <= macc_pkg::SHORT_WIN_RST;
            r_long_win  <= macc_pkg::LONG_WIN_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                macc_pkg::REG_SHORT_WIN: r_short_win <= pwdata[WW-1:0];
                macc_pkg::REG_LONG_WIN:  r_long_win  <= pwdata[WW-1:0];
                default:                 r_short_win <= r_short_win;
            endcase
        end
    end

    assign prdata = (reg_sel == macc_pkg::REG_LONG_WIN) ? 32'(r_long_win) : 32'(r_short_win);

    // clamp to 1..WINDOW_MAX
    always_comb begin
        s_len = r_short_win;
        if (r_short_win == '0) begin
            s_len = WW'(1);
        end else if (r_short_win > WW'(macc_pkg::WINDOW_MAX)) begin
            s_len = WW'(macc_pkg::WINDOW_MAX);
        end
        l_len = r_long_win;
        if (r_long_win == '0) begin
            l_len = WW'(1);
        end else if (r_long_win > WW'(macc_pkg::WINDOW_MAX)) begin
            l_len = WW'(macc_pkg::WINDOW_MAX);
        end
    end

    macc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_price (i_price),
        .i_last  (i_last),
        .i_s_len (s_len),
        .i_l_len (l_len),
        .i_cfg_wr(cfg_wr),
        .o_head  (head),
        .i_pop   (q_pop)
    );

    macc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (q_pop),
        .i_s_len  (s_len),
        .i_l_len  (l_len),
        .o_empty  (empty),
        .i_res_pop(pop),
        .o_result (result)
    );

    assign o_crossing_count = result.crossing_count;
    assign o_crossed        = result.crossed;
    assign o_averages_ready = result.averages_ready;
    assign o_side           = result.side;
    assign o_end_of_series  = result.end_of_series;

endmodule

// ===== rtl/macc_front.sv =====
// Front end: accepts samples, tags them with history slot and window flags, queues them.
module macc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [macc_pkg::PRICE_W-1:0]  i_price,
    input  logic                          i_last,
    input  logic [macc_pkg::WIN_W-1:0]    i_s_len,
    input  logic [macc_pkg::WIN_W-1:0]    i_l_len,
    input  logic                          i_cfg_wr,
    output macc_pkg::t_queue_head         o_head,
    input  logic                          i_pop
);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int WW     = macc_pkg::WIN_W;
    localparam int PW     = macc_pkg::PTR_W;

    logic [PW-1:0]     r_wp;
    logic [WW-1:0]     r_seen;
    logic [PW-1:0]     n_wp;
    logic [WW-1:0]     n_seen;
    logic [WW-1:0]     seen_inc;
    logic [WW-1:0]     need;
    logic              accept;
    macc_pkg::t_item   item;

    macc_pkg::t_item   r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_full = (r_count == (QPTR_W+1)'(QDEPTH));
    assign accept = i_push && !o_full;
    assign need   = (i_s_len > i_l_len) ? i_s_len : i_l_len;

    // fill count saturates at the history depth
    assign seen_inc = (r_seen == WW'(macc_pkg::WINDOW_MAX)) ? r_seen : r_seen + WW'(1);

    always_comb begin
        item.price  = i_price;
        item.wp     = r_wp;
        item.last   = i_last;
        item.first  = (r_seen == '0);
        item.drop_s = (r_seen >= i_s_len);
        item.drop_l = (r_seen >= i_l_len);
        item.ready  = (seen_inc >= need);
    end

    always_comb begin
        n_wp   = r_wp;
        n_seen = r_seen;
        if (i_cfg_wr) begin
            n_wp   = '0;
            n_seen = '0;
        end else if (accept) begin
            if (i_last) begin
                n_wp   = '0;
                n_seen = '0;
            end else begin
                n_wp   = r_wp + PW'(1);
                n_seen = seen_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_seen   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wp   <= n_wp;
            r_seen <= n_seen;
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({accept, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_q[r_rd_ptr];

endmodule

// ===== rtl/macc_back.sv =====
// Back end: history memory, running sums, cross-multiply compare, crossing count, result queue.
module macc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  macc_pkg::t_queue_head         i_head,
    output logic                          o_pop,
    input  logic [macc_pkg::WIN_W-1:0]    i_s_len,
    input  logic [macc_pkg::WIN_W-1:0]    i_l_len,
    output logic                          o_empty,
    input  logic                          i_res_pop,
    output macc_pkg::t_result             o_result
);

    localparam int OUT_DEPTH = 8;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = OPTR_W + 2;
    localparam int SW        = macc_pkg::SUM_W;
    localparam int XW        = macc_pkg::PROD_W;
    localparam int PW        = macc_pkg::PTR_W;
    localparam int CW        = macc_pkg::COUNT_W;

    // stage 1: history read
    logic [macc_pkg::PRICE_W-1:0] r_hist [macc_pkg::WINDOW_MAX];
    logic [macc_pkg::PRICE_W-1:0] r_aged_s;
    logic [macc_pkg::PRICE_W-1:0] r_aged_l;
    logic [PW-1:0]                addr_s;
    logic [PW-1:0]                addr_l;
    logic                         r_v1;
    macc_pkg::t_item              r_it1;

    // stage 2: running sums (also series state)
    logic [SW-1:0]   r_ssum;
    logic [SW-1:0]   r_lsum;
    logic [SW-1:0]   n_ssum;
    logic [SW-1:0]   n_lsum;
    logic            r_v2;
    macc_pkg::t_item r_it2;

    // stage 3: cross products
    logic [XW-1:0]   r_lhs;
    logic [XW-1:0]   r_rhs;
    logic            r_v3;
    macc_pkg::t_item r_it3;

    // stage 4: side and count state
    logic            r_side_valid;
    logic [1:0]      r_side;
    logic [CW-1:0]   r_cnt;
    logic            n_side_valid;
    logic [1:0]      n_side;
    logic [CW-1:0]   n_cnt;
    logic            crossed;
    logic            gt;
    logic            lt;
    logic            prev_valid;
    logic [1:0]      prev_side;
    logic [CW-1:0]   prev_cnt;
    macc_pkg::t_result res;

    // result queue
    macc_pkg::t_result r_out [OUT_DEPTH];
    logic [OPTR_W-1:0] r_owr;
    logic [OPTR_W-1:0] r_ord;
    logic [OCNT_W-1:0] r_ocnt;
    logic [OCNT_W-1:0] occupancy;
    logic              out_pop;

    // only issue when every in-flight item is sure of a result slot
    assign occupancy = r_ocnt + OCNT_W'(r_v1) + OCNT_W'(r_v2) + OCNT_W'(r_v3);
    assign o_pop     = i_head.valid && (occupancy < OCNT_W'(OUT_DEPTH));

    assign addr_s = i_head.item.wp - i_s_len[PW-1:0];
    assign addr_l = i_head.item.wp - i_l_len[PW-1:0];

    // read-before-write: a full-depth window reads the slot being overwritten
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_aged_s             <= r_hist[addr_s];
            r_aged_l             <= r_hist[addr_l];
            r_hist[i_head.item.wp] <= i_head.item.price;
        end
    end

    always_comb begin
        n_ssum = (r_it1.first ? '0 : r_ssum) + SW'(r_it1.price)
                 - (r_it1.drop_s ? SW'(r_aged_s) : '0);
        n_lsum = (r_it1.first ? '0 : r_lsum) + SW'(r_it1.price)
                 - (r_it1.drop_l ? SW'(r_aged_l) : '0);
    end

    always_comb begin
        gt         = (r_lhs > r_rhs);
        lt         = (r_lhs < r_rhs);
        prev_valid = r_it3.first ? 1'b0 : r_side_valid;
        prev_side  = r_it3.first ? macc_pkg::SIDE_NONE : r_side;
        prev_cnt   = r_it3.first ? '0 : r_cnt;
        n_side_valid = prev_valid;
        n_side       = prev_side;
        crossed      = 1'b0;
        if (r_it3.ready) begin
            if (!prev_valid) begin
                n_side_valid = 1'b1;
                n_side = gt ? macc_pkg::SIDE_UP : (lt ? macc_pkg::SIDE_DOWN : macc_pkg::SIDE_NONE);
            end else if (prev_side == macc_pkg::SIDE_UP && lt) begin
                n_side  = macc_pkg::SIDE_DOWN;
                crossed = 1'b1;
            end else if (prev_side == macc_pkg::SIDE_DOWN && gt) begin
                n_side  = macc_pkg::SIDE_UP;
                crossed = 1'b1;
            end
        end
        n_cnt = (crossed && prev_cnt != '1) ? prev_cnt + CW'(1) : prev_cnt;
        res.crossing_count = n_cnt;
        res.crossed        = crossed;
        res.averages_ready = r_it3.ready;
        res.side           = n_side;
        res.end_of_series  = r_it3.last;
    end

    assign out_pop = i_res_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_side_valid <= 1'b0;
            r_side       <= macc_pkg::SIDE_NONE;
            r_cnt        <= '0;
            r_owr        <= '0;
            r_ord        <= '0;
            r_ocnt       <= '0;
        end else begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3) begin
                r_side_valid <= n_side_valid;
                r_side       <= n_side;
                r_cnt        <= n_cnt;
                r_owr        <= r_owr + OPTR_W'(1);
            end
            if (out_pop) begin
                r_ord <= r_ord + OPTR_W'(1);
            end
            case ({r_v3, out_pop})
                2'b10:   r_ocnt <= r_ocnt + OCNT_W'(1);
                2'b01:   r_ocnt <= r_ocnt - OCNT_W'(1);
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_it1 <= i_head.item;
        end
        if (r_v1) begin
            r_it2  <= r_it1;
            r_ssum <= n_ssum;
            r_lsum <= n_lsum;
        end
        if (r_v2) begin
            r_it3 <= r_it2;
            r_lhs <= XW'(r_ssum) * XW'(i_l_len);
            r_rhs <= XW'(r_lsum) * XW'(i_s_len);
        end
        if (r_v3) begin
            r_out[r_owr] <= res;
        end
    end

    assign o_empty  = (r_ocnt == '0);
    assign o_result = r_out[r_ord];

endmodule

// ===== test/moving_average_crossover_counter_tb.sv =====
// Self-checking testbench for the moving-average crossover counter.
module moving_average_crossover_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;  // cycles with nothing moving before we call it hung
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills both queues
    localparam int COUNT_TOP   = 65535; // crossing count saturates here

    // receiver behaviors
    typedef enum int {RX_EAGER, RX_COIN, RX_COMB} t_rx_style;

    // ---------------------------------------------------------------- DUT side
    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          push;
    logic                          full;
    logic [macc_pkg::PRICE_W-1:0]  i_price;
    logic                          i_last;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [macc_pkg::COUNT_W-1:0]  o_crossing_count;
    logic                          o_crossed;
    logic                          o_averages_ready;
    logic signed [1:0]             o_side;
    logic                          o_end_of_series;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    moving_average_crossover_counter i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_price          (i_price),
        .i_last           (i_last),
        .empty            (empty),
        .pop              (pop),
        .o_crossing_count (o_crossing_count),
        .o_crossed        (o_crossed),
        .o_averages_ready (o_averages_ready),
        .o_side           (o_side),
        .o_end_of_series  (o_end_of_series),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #2 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor state
    // Own copy of the window registers and the series state. Sums are kept
    // in 64 bits so the cross-multiplied compare is exact.
    logic [macc_pkg::WIN_W-1:0]    short_cfg;
    logic [macc_pkg::WIN_W-1:0]    long_cfg;
    logic [macc_pkg::PRICE_W-1:0]  history [macc_pkg::WINDOW_MAX];
    int                            hist_ptr;
    longint unsigned               short_total;
    longint unsigned               long_total;
    int                            fill;
    bit                            side_known;
    logic [1:0]                    side_now;
    int unsigned                   crossings;

    // results owed by the block, oldest first
    macc_pkg::t_result             crossing_reports [$];

    // ---------------------------------------------------------------- run bookkeeping
    int                   mismatches = 0;
    int                   results_seen = 0;
    int                   crossed_seen = 0;
    int                   samples_sent = 0;
    int                   window_writes = 0;
    int                   full_cycles = 0;
    int                   quiet = 0;

    // sender pacing
    int                   burst_left;
    bit                   steady;

    // receiver pacing; test code writes these only at rising-edge time steps,
    // the receiver reads them at falling edges
    t_rx_style            rx_style;
    int                   hold_req;
    int                   hold_seen = 0;
    int                   hold_left = 0;
    int                   rx_tick = 0;

    // ---------------------------------------------------------------- predictor
    function automatic void clear_series();
        foreach (history[k]) history[k] = '0;
        hist_ptr    = 0;
        short_total = 0;
        long_total  = 0;
        fill        = 0;
        side_known  = 1'b0;
        side_now    = macc_pkg::SIDE_NONE;
        crossings   = 0;
    endfunction

    // 0 behaves as 1, anything past the history depth as the full depth
    function automatic int window_len(logic [macc_pkg::WIN_W-1:0] w);
        if (w == 0) return 1;
        if (w > macc_pkg::WINDOW_MAX) return macc_pkg::WINDOW_MAX;
        return int'(w);
    endfunction

    function automatic macc_pkg::t_result step_crossover(logic [macc_pkg::PRICE_W-1:0] price,
                                                         logic last);
        int                s_len;
        int                l_len;
        int                need;
        longint unsigned   lhs;
        longint unsigned   rhs;
        bit                flipped;
        macc_pkg::t_result r;
        s_len   = window_len(short_cfg);
        l_len   = window_len(long_cfg);
        need    = (s_len > l_len) ? s_len : l_len;
        flipped = 1'b0;
        r       = '0;
        // aged samples leave the sums before the new one is written
        if (fill >= s_len)
            short_total -= history[(hist_ptr + macc_pkg::WINDOW_MAX - s_len)
                                   % macc_pkg::WINDOW_MAX];
        if (fill >= l_len)
            long_total -= history[(hist_ptr + macc_pkg::WINDOW_MAX - l_len)
                                  % macc_pkg::WINDOW_MAX];
        short_total += price;
        long_total  += price;
        history[hist_ptr] = price;
        hist_ptr = (hist_ptr + 1) % macc_pkg::WINDOW_MAX;
        if (fill < macc_pkg::WINDOW_MAX) fill++;
        if (fill >= need) begin
            // averages compared without division
            lhs = short_total * longint'(l_len);
            rhs = long_total * longint'(s_len);
            r.averages_ready = 1'b1;
            if (!side_known) begin
                // first compare picks the side; a tie stays neutral for the series
                side_known = 1'b1;
                if (lhs > rhs)
                    side_now = macc_pkg::SIDE_UP;
                else if (lhs < rhs)
                    side_now = macc_pkg::SIDE_DOWN;
                else
                    side_now = macc_pkg::SIDE_NONE;
            end else if (side_now == macc_pkg::SIDE_UP && lhs < rhs) begin
                side_now = macc_pkg::SIDE_DOWN;
                flipped  = 1'b1;
            end else if (side_now == macc_pkg::SIDE_DOWN && lhs > rhs) begin
                side_now = macc_pkg::SIDE_UP;
                flipped  = 1'b1;
            end
            if (flipped && crossings < COUNT_TOP) crossings++;
        end
        r.crossing_count = macc_pkg::COUNT_W'(crossings);
        r.crossed        = flipped;
        r.side           = side_now;
        r.end_of_series  = last;
        if (last) clear_series();
        return r;
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endtask

    // ---------------------------------------------------------------- receiver
    // Pop changes at falling edges. A hold request parks pop low for a long
    // stretch so the result queue and then the input queue fill up.
    always @(negedge i_clk) begin
        rx_tick++;
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            pop = 1'b0;
            hold_left--;
        end else begin
            case (rx_style)
                RX_EAGER: pop = 1'b1;
                RX_COIN:  pop = ($urandom_range(0, 99) < 60);
                default:  pop = (rx_tick % 9) < 5;
            endcase
        end
    end

    // ---------------------------------------------------------------- result check
    always @(posedge i_clk) begin : check_results
        macc_pkg::t_result got;
        macc_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            got = {o_crossing_count, o_crossed, o_averages_ready, o_side, o_end_of_series};
            results_seen++;
            if (crossing_reports.size() == 0) begin
                note_mismatch($sformatf("result %0d arrived with nothing owed", results_seen));
            end else begin
                want = crossing_reports.pop_front();
                if (want.crossed) crossed_seen++;
                if (got !== want)
                    note_mismatch($sformatf({"result %0d: want count %0d crossed %0b ",
                        "ready %0b side %0d end %0b; got count %0d crossed %0b ready %0b ",
                        "side %0d end %0b"}, results_seen,
                        want.crossing_count, want.crossed, want.averages_ready,
                        $signed(want.side), want.end_of_series,
                        got.crossing_count, got.crossed, got.averages_ready,
                        $signed(got.side), got.end_of_series));
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    // Counts cycles in which no item moves on either side and no register
    // access runs; the longest legal quiet stretch is the hold-off.
    always @(posedge i_clk) begin
        if (push && full) full_cycles++;
        if (!i_rst_n || (push && !full) || (pop && !empty) || psel)
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("nothing moved for %0d cycles, run abandoned", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sender
    // Called right after a rising edge. Push stays high across back-to-back
    // items; between bursts it drops for a random gap, or not at all.
    task automatic offer_price(input logic [macc_pkg::PRICE_W-1:0] price, input logic last);
        int gap;
        if (!steady && burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                @(negedge i_clk) push = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        push    = 1'b1;
        i_price = price;
        i_last  = last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        crossing_reports.push_back(step_crossover(price, last));
        samples_sent++;
    endtask

    // stop offering and wait for every owed result plus pipeline slack
    task automatic drain();
        @(negedge i_clk) push = 1'b0;
        while (crossing_reports.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- config port
    task automatic read_window(input logic idx, input logic [macc_pkg::WIN_W-1:0] want);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk) penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== 32'(want))
            note_mismatch($sformatf("window register %0d reads %0h, want %0h",
                                    idx, prdata, want));
        @(negedge i_clk) begin
            psel    = 1'b0;
            penable = 1'b0;
        end
        @(posedge i_clk);
    endtask

    // Only with the block idle. Upper data bits carry junk that must be dropped.
    task automatic write_window(input logic idx, input logic [macc_pkg::WIN_W-1:0] value);
        drain();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {23'($urandom), value};
        @(negedge i_clk) penable = 1'b1;
        @(posedge i_clk);
        // register taken at this edge, and the series restarts
        if (idx == macc_pkg::REG_SHORT_WIN)
            short_cfg = value;
        else
            long_cfg = value;
        clear_series();
        @(negedge i_clk) begin
            psel    = 1'b0;
            penable = 1'b0;
            pwrite  = 1'b0;
        end
        read_window(idx, value);
        window_writes++;
    endtask

    // ---------------------------------------------------------------- tests
    // Reset windows 5/20; series ends before either window fills, so no
    // compare and a zero count. Covers the price extremes and last.
    task automatic test_short_series();
        logic [macc_pkg::PRICE_W-1:0] seq [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h00FF};
        read_window(macc_pkg::REG_SHORT_WIN, macc_pkg::SHORT_WIN_RST);
        read_window(macc_pkg::REG_LONG_WIN, macc_pkg::LONG_WIN_RST);
        foreach (seq[k]) offer_price(seq[k], k == 3);
    endtask

    // 1 vs 2 windows: the side follows whether the price rose, so a zigzag
    // crosses on nearly every item.
    task automatic test_fast_crossings();
        logic [macc_pkg::PRICE_W-1:0] seq [8] = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                                                  16'h0001, 16'hFFFE, 16'h7FFF, 16'h0000};
        write_window(macc_pkg::REG_SHORT_WIN, 9'd1);
        write_window(macc_pkg::REG_LONG_WIN, 9'd2);
        foreach (seq[k]) offer_price(seq[k], k == 7);
    endtask

    // short window longer than long: compare starts when the short one fills
    task automatic test_short_longer_than_long();
        logic [macc_pkg::PRICE_W-1:0] seq [6] = '{16'd10, 16'd20, 16'd30, 16'd5, 16'd5, 16'd60};
        write_window(macc_pkg::REG_SHORT_WIN, 9'd3);
        write_window(macc_pkg::REG_LONG_WIN, 9'd2);
        foreach (seq[k]) offer_price(seq[k], k == 5);
    endtask

    // flat start makes the first compare a tie; side then stays neutral
    task automatic test_neutral_first();
        logic [macc_pkg::PRICE_W-1:0] seq [6] = '{16'd100, 16'd100, 16'd100,
                                                  16'd200, 16'd50, 16'd300};
        write_window(macc_pkg::REG_SHORT_WIN, 9'd1);
        write_window(macc_pkg::REG_LONG_WIN, 9'd3);
        foreach (seq[k]) offer_price(seq[k], k == 5);
    endtask

    // receiver parks for a long stretch while items keep coming: full must
    // rise and nothing may be lost or duplicated
    task automatic test_backpressure();
        int k;
        write_window(macc_pkg::REG_SHORT_WIN, 9'd4);
        write_window(macc_pkg::REG_LONG_WIN, 9'd9);
        rx_style = RX_EAGER;
        steady   = 1'b1;
        hold_req++;
        for (k = 0; k < 80; k++)
            offer_price(macc_pkg::PRICE_W'($urandom), k == 79);
        steady = 1'b0;
    endtask

    // Several window settings including 0, 256 and 511. Series lengths mostly
    // reach past the longer window; prices are a trending walk with noise.
    task automatic test_random_series();
        int shorts [8] = '{3, 0, 16, 2, 256, 7, 1, 40};
        int longs  [8] = '{8, 3, 4, 0, 9, 31, 511, 12};
        int counts [8] = '{70, 70, 80, 70, 260, 70, 260, 70};
        int level;
        int trend;
        int need;
        int left;
        int run;
        int k;
        logic [macc_pkg::PRICE_W-1:0] price;
        level = 16'h4000;
        trend = 1;
        foreach (shorts[ph]) begin
            write_window(macc_pkg::REG_SHORT_WIN, macc_pkg::WIN_W'(shorts[ph]));
            write_window(macc_pkg::REG_LONG_WIN, macc_pkg::WIN_W'(longs[ph]));
            need = window_len(short_cfg);
            if (window_len(long_cfg) > need) need = window_len(long_cfg);
            left = counts[ph];
            while (left > 0) begin
                rx_style = t_rx_style'($urandom_range(0, 2));
                if ($urandom_range(0, 4) == 0)
                    run = $urandom_range(1, need);        // ends at or before the first compare
                else
                    run = $urandom_range(need, need + 60);
                if (run > left) run = left;
                for (k = 1; k <= run; k++) begin
                    if ($urandom_range(0, 3) == 0) begin
                        price = macc_pkg::PRICE_W'($urandom);
                    end else begin
                        if ($urandom_range(0, 11) == 0) trend = -trend;
                        level += trend * $urandom_range(0, 900) + $urandom_range(0, 600) - 300;
                        if (level > 65535) begin
                            level = 65535;
                            trend = -1;
                        end else if (level < 0) begin
                            level = 0;
                            trend = 1;
                        end
                        price = macc_pkg::PRICE_W'(level);
                    end
                    offer_price(price, k == run);
                end
                left -= run;
            end
        end
    endtask

    // ---------------------------------------------------------------- main
    initial begin
        i_rst_n    = 1'b0;
        push       = 1'b0;
        i_price    = '0;
        i_last     = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        burst_left = 0;
        steady     = 1'b0;
        rx_style   = RX_EAGER;
        hold_req   = 0;
        short_cfg  = macc_pkg::SHORT_WIN_RST;
        long_cfg   = macc_pkg::LONG_WIN_RST;
        clear_series();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_short_series();
        test_fast_crossings();
        test_short_longer_than_long();
        test_neutral_first();
        test_backpressure();
        test_random_series();
        drain();

        $display("covered %0d samples over %0d window writes, %0d results checked, %0d crossed",
                 samples_sent, window_writes, results_seen, crossed_seen);
        $display("input held off by a full queue on %0d cycles, %0d mismatches",
                 full_cycles, mismatches);
        if (mismatches == 0 && crossing_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== moving_average_crossover_counter.f =====
rtl/macc_pkg.sv
rtl/macc_front.sv
rtl/macc_back.sv
rtl/moving_average_crossover_counter.sv
test/moving_average_crossover_counter_tb.sv
